### hw/rtl/wto_pkg.sv
package wto_pkg;

    // Fixed geometry of the oscillator.
    localparam int TABLE_SIZE  = 256;
    localparam int PHASE_BITS  = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_BITS    = $clog2(TABLE_SIZE);
    localparam int FRAC_BITS   = 16;
    localparam int AMP_BITS    = 16;
    localparam int STEP_BITS   = 32;

    // Shared multiplier: one spare bit so the unsigned fraction fits as signed.
    localparam int MUL_BITS  = 17;
    localparam int PROD_BITS = 2 * MUL_BITS;

    // Decoupling queue between the front and the back.
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

    // Saturation bounds of the scaled sample.
    localparam logic signed [PROD_BITS-15-1:0] SAT_HI =
        (PROD_BITS-15)'((1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [PROD_BITS-15-1:0] SAT_LO = -SAT_HI - 1;

    // Square wave levels.
    localparam logic signed [15:0] SQ_LOW  = 16'sh8000;
    localparam logic signed [15:0] SQ_HIGH = 16'sh7fff;

    typedef enum logic [1:0] {
        SHAPE_SINE   = 2'd0,
        SHAPE_SQUARE = 2'd1,
        SHAPE_SAW    = 2'd2,
        SHAPE_TRI    = 2'd3
    } t_shape;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL1,
        ST_WAVE,
        ST_MUL2
    } t_state;

    // One queued item, already split into table index and fraction.
    typedef struct packed {
        logic [IDX_BITS-1:0]        idx;
        logic [FRAC_BITS-1:0]       frac;
        logic                       half;
        logic signed [AMP_BITS-1:0] amp;
        logic                       blk;
    } t_entry;

    // Quarter of a sine period, Q1.15.
    localparam logic signed [15:0] QUARTER_WAVE [0:64] = '{
            0,   804,  1608,  2410,  3212,  4011,  4808,  5602,
         6393,  7179,  7962,  8739,  9512, 10278, 11039, 11793,
        12539, 13279, 14010, 14732, 15446, 16151, 16846, 17530,
        18204, 18868, 19519, 20159, 20787, 21403, 22005, 22594,
        23170, 23731, 24279, 24811, 25329, 25832, 26319, 26790,
        27245, 27683, 28105, 28510, 28898, 29268, 29621, 29956,
        30273, 30571, 30852, 31113, 31356, 31580, 31785, 31971,
        32137, 32285, 32412, 32521, 32609, 32678, 32728, 32757,
        32767
    };

    // Full sine table entry built from the quarter wave by symmetry.
    function automatic logic signed [15:0] rom_entry(input logic [IDX_BITS-1:0] i);
        logic [8:0] p;
        logic [8:0] q;
        p = {1'b0, i};
        if (p <= 9'd64) begin
            q = p;
            return QUARTER_WAVE[q[6:0]];
        end else if (p < 9'd128) begin
            q = 9'd128 - p;
            return QUARTER_WAVE[q[6:0]];
        end else if (p <= 9'd192) begin
            q = p - 9'd128;
            return -QUARTER_WAVE[q[6:0]];
        end else begin
            q = 9'd256 - p;
            return -QUARTER_WAVE[q[6:0]];
        end
    endfunction

endpackage

### hw/rtl/wto_front.sv
module wto_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic [wto_pkg::STEP_BITS-1:0]  i_phase_step,
    input  logic signed [wto_pkg::AMP_BITS-1:0] i_amplitude,
    input  logic                           i_block_end,
    input  logic                           i_q_full,
    output logic                           o_in_stall,
    output logic                           o_push,
    output wto_pkg::t_entry                o_entry
);
    import wto_pkg::*;

    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;

    // Items are taken whenever the queue has room.
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Split the phase held before the step into index, fraction and half flag.
    always_comb begin
        o_entry.idx  = r_phase[PHASE_BITS-1 -: IDX_BITS];
        o_entry.frac = r_phase[PHASE_BITS-IDX_BITS-1 -: FRAC_BITS];
        o_entry.half = r_phase[PHASE_BITS-1];
        o_entry.amp  = i_amplitude;
        o_entry.blk  = i_block_end;
    end

    // The accumulator wraps modulo the phase width.
    assign n_phase = r_phase + PHASE_BITS'(i_phase_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (o_push) begin
            r_phase <= n_phase;
        end
    end

endmodule

### hw/rtl/wto_queue.sv
module wto_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wto_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output wto_pkg::t_entry o_entry
);
    import wto_pkg::*;

    t_entry                r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wptr;
    logic [Q_PTR_BITS-1:0] r_rptr;
    logic [Q_PTR_BITS:0]   r_count;

    assign o_full  = (r_count == (Q_PTR_BITS+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rptr];

    // Pointer and fill bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

endmodule

### hw/rtl/wto_back.sv
module wto_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  wto_pkg::t_shape          i_shape,
    input  logic                     i_q_valid,
    input  wto_pkg::t_entry          i_q_entry,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [15:0]       o_sample,
    output logic                     o_block_end_out
);
    import wto_pkg::*;

    t_state r_state;
    t_state n_state;

    logic signed [15:0]           r_a;
    logic signed [16:0]           r_d;
    logic [FRAC_BITS-1:0]         r_frac;
    logic                         r_half;
    logic signed [AMP_BITS-1:0]   r_amp;
    logic                         r_blk;
    logic signed [PROD_BITS-1:0]  r_p;
    logic signed [15:0]           r_w;
    logic                         r_out_valid;
    logic signed [15:0]           r_sample;
    logic                         r_blk_out;

    logic                         ld_entry;
    logic                         ld_p;
    logic                         ld_w;
    logic                         ld_out;
    logic                         out_free;

    logic [IDX_BITS-1:0]          idx_next;
    logic signed [15:0]           rom_a;
    logic signed [15:0]           rom_b;
    logic signed [16:0]           rom_d;
    logic signed [MUL_BITS-1:0]   mul_a;
    logic signed [MUL_BITS-1:0]   mul_b;
    logic signed [PROD_BITS-1:0]  mul_p;
    logic signed [17:0]           sine_w;
    logic signed [15:0]           wave_w;
    logic signed [PROD_BITS-16:0] scaled;
    logic signed [15:0]           sat_sample;

    assign out_free = !r_out_valid || !i_out_stall;

    // Next state: pop, interpolate, pick the waveform, scale.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_q_valid) n_state = ST_MUL1;
            ST_MUL1: n_state = ST_WAVE;
            ST_WAVE: n_state = ST_MUL2;
            ST_MUL2: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Per-state load enables.
    always_comb begin
        ld_entry = 1'b0;
        ld_p     = 1'b0;
        ld_w     = 1'b0;
        ld_out   = 1'b0;
        case (r_state)
            ST_IDLE: ld_entry = i_q_valid;
            ST_MUL1: ld_p     = 1'b1;
            ST_WAVE: ld_w     = 1'b1;
            ST_MUL2: ld_out   = out_free;
            default: ld_entry = 1'b0;
        endcase
    end

    assign o_pop = ld_entry;

    // Table lookup of the entry and its neighbor; the index wraps at the end.
    assign idx_next = i_q_entry.idx + 1'b1;
    assign rom_a    = rom_entry(i_q_entry.idx);
    assign rom_b    = rom_entry(idx_next);
    assign rom_d    = {rom_b[15], rom_b} - {rom_a[15], rom_a};

    // One multiplier serves the interpolation and the amplitude scaling.
    always_comb begin
        if (r_state == ST_MUL1) begin
            mul_a = r_d;
            mul_b = {1'b0, r_frac};
        end else begin
            mul_a = {r_w[15], r_w};
            mul_b = {r_amp[AMP_BITS-1], r_amp};
        end
    end
    assign mul_p = mul_a * mul_b;

    // Interpolated sine: a plus the floored slope term.
    assign sine_w = {{2{r_a[15]}}, r_a} + r_p[PROD_BITS-1:FRAC_BITS];

    always_comb begin
        case (i_shape)
            SHAPE_SINE:   wave_w = sine_w[15:0];
            SHAPE_SQUARE: wave_w = r_half ? SQ_HIGH : SQ_LOW;
            default:      wave_w = '0;
        endcase
    end

    // Floor shift by 15 and saturate to the sample range.
    assign scaled = mul_p[PROD_BITS-1:15];
    always_comb begin
        if (scaled > SAT_HI) begin
            sat_sample = SAT_HI[15:0];
        end else if (scaled < SAT_LO) begin
            sat_sample = SAT_LO[15:0];
        end else begin
            sat_sample = scaled[15:0];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (ld_entry) begin
            r_a    <= rom_a;
            r_d    <= rom_d;
            r_frac <= i_q_entry.frac;
            r_half <= i_q_entry.half;
            r_amp  <= i_q_entry.amp;
            r_blk  <= i_q_entry.blk;
        end
        if (ld_p) begin
            r_p <= mul_p;
        end
        if (ld_w) begin
            r_w <= wave_w;
        end
        if (ld_out) begin
            r_sample  <= sat_sample;
            r_blk_out <= r_blk;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sample        = r_sample;
    assign o_block_end_out = r_blk_out;

endmodule

### hw/rtl/wavetable_oscillator.sv
// Channel  | Direction | Handshake                | Payload
// in       | input     | i_in_valid / o_in_stall  | i_phase_step, i_amplitude, i_block_end
// out      | output    | o_out_valid / i_out_stall| o_sample, o_block_end_out
// cfg      | input     | i_cfg_valid / o_cfg_ready| i_cfg_data (wave shape)
//
// The back end takes each item through pop with table lookup, interpolation
// multiply, waveform select and amplitude multiply; one 17x17 multiplier is used twice.
// A two-entry queue sits between the phase accumulator and the back end.
// Reset is synchronous and clears the phase, the wave shape, the queue and the FSM.
// The input stalls only while the queue is full; the back end holds its last step
// while the output register is full and stalled.
module wavetable_oscillator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [wto_pkg::STEP_BITS-1:0]  i_phase_step,
    input  logic signed [wto_pkg::AMP_BITS-1:0] i_amplitude,
    input  logic                           i_block_end,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [15:0]             o_sample,
    output logic                           o_block_end_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_data
);
    import wto_pkg::*;

    t_shape r_shape;
    logic   q_full;
    logic   q_valid;
    logic   push;
    logic   pop;
    t_entry push_entry;
    t_entry head_entry;

    // Wave shape register.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape <= SHAPE_SINE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_shape <= t_shape'(i_cfg_data);
        end
    end

    wto_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_phase_step (i_phase_step),
        .i_amplitude  (i_amplitude),
        .i_block_end  (i_block_end),
        .i_q_full     (q_full),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    wto_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    wto_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_shape         (r_shape),
        .i_q_valid       (q_valid),
        .i_q_entry       (head_entry),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_sample        (o_sample),
        .o_block_end_out (o_block_end_out)
    );

    // The back end only pops an entry that is there.
    a_pop_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

    // Back end is busy after each pop and cannot pop back to back.
    a_pop_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> !pop)
        else $error("back-to-back pops");

    // A full queue never takes another item.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push)
        else $error("push into full queue");

    // Reset leaves no result pending.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

### test/wavetable_oscillator_tb.sv
module wavetable_oscillator_tb;
    import wto_pkg::*;

    typedef struct {
        logic [31:0]        step;
        logic signed [15:0] amp;
        logic               blk;
    } t_tone_req;

    typedef struct {
        logic signed [15:0] sample;
        logic               blk;
    } t_tone_out;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [31:0]         i_phase_step = '0;
    logic signed [15:0]  i_amplitude = '0;
    logic                i_block_end = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic signed [15:0]  o_sample;
    logic                o_block_end_out;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_data = '0;

    // Requests waiting for the driver, and samples the block still owes us.
    t_tone_req pending_reqs[$];
    t_tone_out owed_samples[$];
    logic      req_held = 1'b0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        error_count = 0;

    // Model copy of the oscillator state.
    logic [31:0] osc_phase = '0;
    t_shape      osc_shape = SHAPE_SINE;

    // Shape used in each random phase; sine gets the largest share.
    t_shape phase_shapes [0:7] = '{SHAPE_SINE, SHAPE_SQUARE, SHAPE_SINE, SHAPE_SAW,
                                  SHAPE_SINE, SHAPE_TRI, SHAPE_SQUARE, SHAPE_SINE};

    // First quarter of one sine period in Q1.15.
    int quarter_sine [0:64] = '{
            0,   804,  1608,  2410,  3212,  4011,  4808,  5602,
         6393,  7179,  7962,  8739,  9512, 10278, 11039, 11793,
        12539, 13279, 14010, 14732, 15446, 16151, 16846, 17530,
        18204, 18868, 19519, 20159, 20787, 21403, 22005, 22594,
        23170, 23731, 24279, 24811, 25329, 25832, 26319, 26790,
        27245, 27683, 28105, 28510, 28898, 29268, 29621, 29956,
        30273, 30571, 30852, 31113, 31356, 31580, 31785, 31971,
        32137, 32285, 32412, 32521, 32609, 32678, 32728, 32757,
        32767
    };

    wavetable_oscillator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_phase_step    (i_phase_step),
        .i_amplitude     (i_amplitude),
        .i_block_end     (i_block_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_sample        (o_sample),
        .o_block_end_out (o_block_end_out),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // One point of the 256-entry sine wave, unfolded from the quarter wave.
    function automatic longint sine_point(input logic [7:0] pos);
        int p;
        p = pos;
        if (p <= 64)
            return quarter_sine[p];
        else if (p < 128)
            return quarter_sine[128 - p];
        else if (p <= 192)
            return -quarter_sine[p - 128];
        else
            return -quarter_sine[256 - p];
    endfunction

    // Linear interpolation between two neighbor points; the last point wraps to the first.
    function automatic longint sine_level(input logic [31:0] ph);
        logic [7:0] idx;
        logic [7:0] idx_next;
        longint     f;
        idx      = ph[31:24];
        idx_next = idx + 8'd1;
        f        = ph[23:8];
        return (sine_point(idx) * (65536 - f) + sine_point(idx_next) * f) >>> 16;
    endfunction

    // Waveform level times the gain, floored and clipped to 16 bits.
    function automatic logic signed [15:0] oscillator_sample(input logic [31:0] ph,
                                                             input t_shape shape,
                                                             input logic signed [15:0] amp);
        longint lvl;
        longint prod;
        case (shape)
            SHAPE_SINE:   lvl = sine_level(ph);
            SHAPE_SQUARE: lvl = ph[31] ? 32767 : -32768;
            default:      lvl = 0;
        endcase
        prod = (lvl * longint'(amp)) >>> 15;
        if (prod > 32767)
            prod = 32767;
        if (prod < -32768)
            prod = -32768;
        return prod[15:0];
    endfunction

    // Driver: presents queued requests and predicts the sample of each accepted one.
    always @(posedge i_clk) begin : drive_proc
        t_tone_req nxt;
        t_tone_out want;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            req_held = 1'b0;
            osc_phase = '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                want.sample = oscillator_sample(osc_phase, osc_shape, i_amplitude);
                want.blk    = i_block_end;
                owed_samples.push_back(want);
                osc_phase = osc_phase + i_phase_step;
                req_held = 1'b0;
            end
            if (!req_held && pending_reqs.size() > 0 &&
                $urandom_range(99, 0) >= send_idle_pct) begin
                nxt = pending_reqs.pop_front();
                i_phase_step <= nxt.step;
                i_amplitude  <= nxt.amp;
                i_block_end  <= nxt.blk;
                req_held = 1'b1;
            end
            i_in_valid <= req_held;
        end
    end

    // Monitor: checks each accepted sample against the oldest prediction.
    always @(posedge i_clk) begin : check_proc
        t_tone_out want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (owed_samples.size() == 0) begin
                    $error("sample %0d arrived with no item outstanding", o_sample);
                    error_count++;
                end else begin
                    want = owed_samples.pop_front();
                    if (o_sample !== want.sample) begin
                        $error("sample: expected %0d, got %0d", want.sample, o_sample);
                        error_count++;
                    end
                    if (o_block_end_out !== want.blk) begin
                        $error("block_end_out: expected %0b, got %0b", want.blk,
                               o_block_end_out);
                        error_count++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    task automatic queue_req(input logic [31:0] step, input logic signed [15:0] amp,
                             input logic blk);
        t_tone_req r;
        r.step = step;
        r.amp  = amp;
        r.blk  = blk;
        pending_reqs.push_back(r);
    endtask

    // Holds the sender back until every queued item has produced its sample.
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_held || owed_samples.size() > 0)
            @(posedge i_clk);
    endtask

    // Writes the wave shape register; only called while the block is idle.
    task automatic write_shape(input t_shape shape);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= shape;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        osc_shape = shape;
    endtask

    // Random request: half full-range steps, the rest audio-rate steps and extreme values.
    task automatic queue_random_req();
        logic [31:0]        step;
        logic signed [15:0] amp;
        case ($urandom_range(9, 0))
            0:       step = 32'h0;
            1:       step = 32'hFFFF_FFFF;
            2, 3, 4: step = $urandom_range(32'h0100_0000, 1);
            default: step = $urandom;
        endcase
        case ($urandom_range(7, 0))
            0:       amp = -16'sd32768;
            1:       amp = 16'sd32767;
            default: amp = 16'($urandom);
        endcase
        queue_req(step, amp, ($urandom_range(3, 0) == 0));
    endtask

    initial begin : stim_proc
        int p;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sine: quarter and half points, the wrap from the last table entry to
        // the first, phase overflow and gain extremes.
        write_shape(SHAPE_SINE);
        queue_req(32'h4000_0000, 16'sd32767, 1'b0);
        queue_req(32'h4000_0000, -16'sd32768, 1'b0);
        queue_req(32'h7FFF_8000, 16'sd32767, 1'b1);
        queue_req(32'hFFFF_FFFF, -16'sd32768, 1'b0);
        queue_req(32'h0000_8001, 16'sd32767, 1'b1);
        queue_req(32'h1234_5678, 16'sd0, 1'b0);
        queue_req(32'hA5A5_A5A5, 16'sd1, 1'b1);
        queue_req(32'h5A5A_5A5A, -16'sd1, 1'b0);
        wait_drained();

        // Square: the low level times the most negative gain must clip.
        write_shape(SHAPE_SQUARE);
        queue_req(32'h8000_0000, -16'sd32768, 1'b0);
        queue_req(32'h8000_0000, -16'sd32768, 1'b1);
        queue_req(32'h7FFF_FFFF, 16'sd32767, 1'b0);
        queue_req(32'h0000_0001, -16'sd32768, 1'b0);
        queue_req(32'h0000_0000, 16'sd16384, 1'b1);
        wait_drained();

        // Saw and triangle give silence whatever the gain.
        write_shape(SHAPE_SAW);
        queue_req(32'hFFFF_FFFF, 16'sd32767, 1'b1);
        queue_req(32'h0000_0000, -16'sd32768, 1'b0);
        queue_req(32'h8000_0000, -16'sd1234, 1'b0);
        wait_drained();
        write_shape(SHAPE_TRI);
        queue_req(32'h4000_0000, -16'sd32768, 1'b0);
        queue_req(32'hC000_0000, 16'sd32767, 1'b1);
        queue_req(32'h0000_0000, 16'sd100, 1'b0);
        wait_drained();

        // Random phases, each with a shape and an idling pattern picked for it.
        for (p = 0; p < 8; p++) begin
            write_shape(phase_shapes[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            repeat (125) queue_random_req();
            wait_drained();
        end

        // Let any stray output show up before the verdict.
        recv_stall_pct = 0;
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin : watchdog_proc
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
hw/rtl/wto_pkg.sv
hw/rtl/wto_front.sv
hw/rtl/wto_queue.sv
hw/rtl/wto_back.sv
hw/rtl/wavetable_oscillator.sv
test/wavetable_oscillator_tb.sv
